[design/kalman_angle_bias_filter_macros.svh]
// Assertion helpers shared by the design files.
// Both macros expect signals named clk and rst in the enclosing module.
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// Same-cycle implication.
`define KABF_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KABF_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/kabf_pkg.sv]
package kabf_pkg;

  localparam int NUM_AXES = 2;

  localparam int CFG_W = 31;
  localparam int DATA_W = 32;
  localparam int US_W = 20;
  localparam int DT_W = 29;
  localparam int OP_W = 33;
  localparam int RES_W = 38;
  localparam int SUM_W = 48;
  localparam int NUM_W = 61;
  localparam int DEN_W = 34;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd268435;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST = 31'd805306;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 31'd8053064;

  localparam logic signed [DATA_W-1:0] ONE_Q28 = 32'sd268435456;

  localparam logic [31:0] US_DEFAULT = 32'd1000;
  localparam logic [31:0] US_MAX = 32'd1000000;

  // Step time conversion: 10^6 = 64 * 15625 and 2^22 = 268 * 15625 + 6804.
  // Division by 15625 is done by multiplying with a rounded-up reciprocal.
  localparam logic [20:0] DT_RECIP_A = 21'd1099512;    // ceil(2^34 / 15625)
  localparam logic [27:0] DT_RECIP_B = 28'd140737489;  // ceil(2^41 / 15625)
  localparam logic [13:0] DT_BLOCK = 14'd15625;
  localparam logic [12:0] DT_FRAC = 13'd6804;
  localparam logic [8:0]  DT_WHOLE = 9'd268;
  localparam logic [12:0] DT_BIAS = 13'd7812;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/kabf_mul.sv]
module kabf_mul (
  input  logic                              clk,
  input  logic signed [kabf_pkg::OP_W-1:0]  a,
  input  logic signed [kabf_pkg::OP_W-1:0]  b,
  output logic signed [kabf_pkg::RES_W-1:0] res
);
  import kabf_pkg::*;

  logic signed [2*OP_W-1:0] prod;
  logic signed [2*OP_W-1:0] rnd;

  // Round to nearest, ties away from zero, on the shift back by 28 bits.
  assign rnd = prod + (prod[2*OP_W-1] ? 66'sd134217727 : 66'sd134217728);

  always_ff @(posedge clk) begin
    prod <= a * b;
    res <= RES_W'(rnd >>> 28);
  end

endmodule

[design/kabf_div.sv]
`include "kalman_angle_bias_filter_macros.svh"

module kabf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [kabf_pkg::NUM_W-1:0]      num,
  input  logic [kabf_pkg::DEN_W-1:0]      den,
  output logic [31:0]                     quo,
  output kabf_pkg::div_stat_t             stat
);
  import kabf_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [31:0]      low;
  logic [3:0]       cnt;
  logic [DEN_W:0]   t1;
  logic [DEN_W:0]   t2;
  logic [DEN_W-1:0] r1;
  logic [DEN_W-1:0] r2;
  logic             b1;
  logic             b2;

  // Two restoring steps per cycle.
  always_comb begin
    t1 = {rem, low[31]};
    b1 = (t1 >= {1'b0, dv});
    r1 = b1 ? DEN_W'(t1 - {1'b0, dv}) : t1[DEN_W-1:0];
    t2 = {r1, low[30]};
    b2 = (t2 >= {1'b0, dv});
    r2 = b2 ? DEN_W'(t2 - {1'b0, dv}) : t2[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem <= DEN_W'(num[NUM_W-1:32]);
        low <= num[31:0];
        dv <= den;
        stat.ovf <= ({5'b0, num} >= {den, 32'b0});
        cnt <= 4'd15;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem <= r2;
        low <= {low[29:0], 2'b00};
        quo <= {quo[29:0], b1, b2};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  `KABF_IMPL(a_no_restart, start, !stat.busy, "divider started while busy")
  `KABF_NEXT(a_done_after_last, stat.busy && cnt == 4'd0 && !start, stat.done, "divider missed done")
  `KABF_IMPL(a_done_idle, stat.done, !stat.busy, "divider done while busy")

endmodule

[design/kalman_angle_bias_filter.sv]
// Channel  | Handshake                  | Beat payload
// ---------+----------------------------+---------------------------------------------------
// input    | in_valid / in_ready        | axis, gyro_rate, measured_angle, elapsed_us
// output   | out_valid / out_ready      | filtered_angle, bias_estimate
// config   | cfg_we (no wait)           | cfg_idx, cfg_data
//
// One input beat is processed at a time; the next beat is accepted only after the result beat
// of the last one is offered. The processing time is set by the shared radix-4 divider, run
// twice per beat for the two gains, the shared two-stage multiplier, issued eleven times, and
// a reciprocal step that turns microseconds into the unsigned Q1.28 step time.
// When the innovation variance is zero the two gain divisions are skipped.
// Reset is synchronous; it restores the noise registers and every axis to its initial state.
// in_ready is high only while the sequencer is idle; a result waiting on out_ready holds the
// write-back step, and a new beat may be accepted while the last result is still waiting.
`include "kalman_angle_bias_filter_macros.svh"

module kalman_angle_bias_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               axis,
  input  logic signed [kabf_pkg::DATA_W-1:0] gyro_rate,
  input  logic signed [kabf_pkg::DATA_W-1:0] measured_angle,
  input  logic [31:0]                        elapsed_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [kabf_pkg::DATA_W-1:0] filtered_angle,
  output logic signed [kabf_pkg::DATA_W-1:0] bias_estimate,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_idx,
  input  logic [kabf_pkg::CFG_W-1:0]         cfg_data
);
  import kabf_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOAD    = 4'd1;
  localparam logic [3:0] ST_DT_GO   = 4'd2;
  localparam logic [3:0] ST_DT_WAIT = 4'd3;
  localparam logic [3:0] ST_MUL1    = 4'd4;
  localparam logic [3:0] ST_PRED    = 4'd5;
  localparam logic [3:0] ST_K0_GO   = 4'd6;
  localparam logic [3:0] ST_K0_WAIT = 4'd7;
  localparam logic [3:0] ST_K1_GO   = 4'd8;
  localparam logic [3:0] ST_K1_WAIT = 4'd9;
  localparam logic [3:0] ST_MUL2    = 4'd10;
  localparam logic [3:0] ST_WB      = 4'd11;

  // Noise registers.
  logic [CFG_W-1:0] angle_noise;
  logic [CFG_W-1:0] bias_noise;
  logic [CFG_W-1:0] meas_noise;

  // Per-axis filter state.
  logic signed [DATA_W-1:0] angle_est [NUM_AXES];
  logic signed [DATA_W-1:0] bias_est [NUM_AXES];
  logic signed [DATA_W-1:0] var_angle [NUM_AXES];
  logic signed [DATA_W-1:0] cov_cross [NUM_AXES];
  logic signed [DATA_W-1:0] var_bias [NUM_AXES];

  logic [3:0] state;
  logic [2:0] idx;
  logic       bad;

  // Latched beat.
  logic                     ax;
  logic signed [DATA_W-1:0] gyro;
  logic signed [DATA_W-1:0] meas;
  logic [US_W-1:0]          us;

  // Step time conversion registers.
  logic [6:0]               dq_a;
  logic [13:0]              dr;
  logic [26:0]              dz;
  logic [13:0]              dq_b;

  // Working registers.
  logic [DT_W-1:0]          dt;
  logic [DT_W-1:0]          dt2;
  logic signed [DATA_W-1:0] ang;
  logic signed [DATA_W-1:0] bia;
  logic signed [DATA_W-1:0] va;
  logic signed [DATA_W-1:0] cc;
  logic signed [DATA_W-1:0] vb;
  logic signed [RES_W-1:0]  m2;
  logic signed [RES_W-1:0]  m3;
  logic signed [RES_W-1:0]  m4;
  logic signed [RES_W-1:0]  m5;
  logic signed [DATA_W-1:0] theta;
  logic signed [DATA_W-1:0] p00;
  logic signed [DATA_W-1:0] p01;
  logic signed [DATA_W-1:0] p11;
  logic signed [DATA_W-1:0] k0;
  logic signed [DATA_W-1:0] k1;
  logic signed [DATA_W-1:0] p01a;
  logic signed [DATA_W-1:0] p10;

  // Shared units.
  logic signed [OP_W-1:0]  mul_a;
  logic signed [OP_W-1:0]  mul_b;
  logic signed [RES_W-1:0] mul_res;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [31:0]             div_quo;
  div_stat_t               div_stat;

  logic signed [OP_W-1:0]   s;
  logic [OP_W-1:0]          s_mag;
  logic [DATA_W-1:0]        n_mag;
  logic signed [OP_W-1:0]   innov;
  logic signed [OP_W-1:0]   dt_op;
  logic signed [OP_W-1:0]   cov_sum;
  logic signed [DATA_W-1:0] cov_new;
  logic [31:0]              us_eff;
  logic                     axis_ok;
  logic [40:0]              dt_prod_a;
  logic [US_W-1:0]          dt_rem;
  logic [26:0]              dt_frac;
  logic [54:0]              dt_prod_b;
  logic [DT_W-1:0]          dt_full;

  kabf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  kabf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Saturate the unsigned quotient into a signed Q4.28 gain.
  function automatic logic signed [DATA_W-1:0] gain_of(input logic [31:0] q,
                                                      input logic ovf,
                                                      input logic neg);
    logic signed [DATA_W-1:0] g;
    if (ovf || q[31]) begin
      g = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      g = neg ? -$signed(q) : $signed(q);
    end
    return g;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign axis_ok = (32'(axis) < NUM_AXES);
  assign us_eff = (elapsed_us == 32'd0 || elapsed_us > US_MAX) ? US_DEFAULT : elapsed_us;

  // Step time dt = round(us * 2^28 / 10^6). With us = 15625 * qa + ra this is
  // qa * 2^22 + ra * 268 + floor((ra * 6804 + 7812) / 15625); both divisions by
  // 15625 are exact reciprocal multiplications for the operand ranges used here.
  assign dt_prod_a = 41'(us) * 41'(DT_RECIP_A);
  assign dt_rem = us - US_W'(dq_a) * US_W'(DT_BLOCK);
  assign dt_frac = 27'(dr) * 27'(DT_FRAC) + 27'(DT_BIAS);
  assign dt_prod_b = 55'(dz) * 55'(DT_RECIP_B);
  assign dt_full = (DT_W'(dq_a) << 22) + DT_W'(dr) * DT_W'(DT_WHOLE) + DT_W'(dq_b);

  assign s = OP_W'(p00) + $signed({2'b00, meas_noise});
  assign s_mag = s[OP_W-1] ? OP_W'(-s) : OP_W'(s);
  assign innov = OP_W'(meas) - OP_W'(theta);
  assign dt_op = $signed({4'b0000, dt});

  // The numerator of the running gain: p00 for the first, p01 for the second.
  assign n_mag = (state == ST_K0_GO) ? (p00[DATA_W-1] ? DATA_W'(-p00) : DATA_W'(p00))
                                     : (p01[DATA_W-1] ? DATA_W'(-p01) : DATA_W'(p01));

  always_comb begin
    div_start = 1'b0;
    div_num = {NUM_W{1'b0}};
    div_den = {DEN_W{1'b0}};
    if ((state == ST_K0_GO && s != '0) || state == ST_K1_GO) begin
      div_start = 1'b1;
      div_num = {n_mag, 29'b0} + NUM_W'(s_mag);
      div_den = {s_mag, 1'b0};
    end
  end

  // Multiplier operand schedule; results return through the multiplier's product and result registers.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MUL1) begin
      case (idx)
        3'd0: begin mul_a = dt_op; mul_b = dt_op; end
        3'd1: begin mul_a = OP_W'(gyro) - OP_W'(bia); mul_b = dt_op; end
        3'd2: begin mul_a = dt_op; mul_b = OP_W'(cc); end
        3'd3: begin mul_a = dt_op; mul_b = OP_W'(vb); end
        3'd4: begin mul_a = $signed({4'b0000, dt2}); mul_b = OP_W'(vb); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == ST_MUL2) begin
      case (idx)
        3'd0: begin mul_a = OP_W'(k0); mul_b = innov; end
        3'd1: begin mul_a = OP_W'(k1); mul_b = innov; end
        3'd2: begin mul_a = OP_W'(k0); mul_b = OP_W'(p01); end
        3'd3: begin mul_a = OP_W'(k1); mul_b = OP_W'(p00); end
        3'd4: begin mul_a = OP_W'(k0); mul_b = OP_W'(p00); end
        3'd5: begin mul_a = OP_W'(k1); mul_b = OP_W'(p01); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Symmetrized cross term: halve the sum, rounding ties away from zero.
  assign cov_sum = OP_W'(p01a) + OP_W'(p10);
  assign cov_new = cov_sum[OP_W-1] ? DATA_W'(cov_sum >>> 1) : DATA_W'((cov_sum + 33'sd1) >>> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise <= BIAS_NOISE_RST;
      meas_noise <= MEAS_NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_BIAS_NOISE:  bias_noise <= cfg_data;
        REG_MEAS_NOISE:  meas_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_est[i] <= '0;
        bias_est[i] <= '0;
        var_angle[i] <= ONE_Q28;
        cov_cross[i] <= '0;
        var_bias[i] <= ONE_Q28;
      end
    end else begin
      // The write-back step sets out_valid itself when it runs.
      if (out_ready && state != ST_WB) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ax <= axis;
            bad <= !axis_ok;
            gyro <= gyro_rate;
            meas <= measured_angle;
            us <= us_eff[US_W-1:0];
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ang <= angle_est[ax];
          bia <= bias_est[ax];
          va <= var_angle[ax];
          cc <= cov_cross[ax];
          vb <= var_bias[ax];
          state <= bad ? ST_WB : ST_DT_GO;
        end
        ST_DT_GO: begin
          dq_a <= dt_prod_a[40:34];
          idx <= '0;
          state <= ST_DT_WAIT;
        end
        ST_DT_WAIT: begin
          case (idx)
            3'd0: dr <= dt_rem[13:0];
            3'd1: dz <= dt_frac;
            3'd2: dq_b <= dt_prod_b[54:41];
            default: ;
          endcase
          if (idx == 3'd3) begin
            dt <= dt_full;
            idx <= '0;
            state <= ST_MUL1;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        ST_MUL1: begin
          case (idx)
            3'd2: dt2 <= mul_res[DT_W-1:0];
            3'd3: m2 <= mul_res;
            3'd4: m3 <= mul_res;
            3'd5: m5 <= mul_res;
            3'd6: m4 <= mul_res;
            default: ;
          endcase
          idx <= idx + 3'd1;
          if (idx == 3'd6) begin
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          theta <= sat32(SUM_W'(ang) + SUM_W'(m2));
          p00 <= sat32(SUM_W'(va) - (SUM_W'(m3) <<< 1) + SUM_W'(m4)
                       + $signed(SUM_W'(angle_noise)));
          p01 <= sat32(SUM_W'(cc) - SUM_W'(m5));
          p11 <= sat32(SUM_W'(vb) + $signed(SUM_W'(bias_noise)));
          state <= ST_K0_GO;
        end
        ST_K0_GO: begin
          if (s == '0) begin
            k0 <= '0;
            k1 <= '0;
            idx <= '0;
            state <= ST_MUL2;
          end else begin
            state <= ST_K0_WAIT;
          end
        end
        ST_K0_WAIT: begin
          if (div_stat.done) begin
            k0 <= gain_of(div_quo, div_stat.ovf, p00[DATA_W-1] ^ s[OP_W-1]);
            state <= ST_K1_GO;
          end
        end
        ST_K1_GO: begin
          state <= ST_K1_WAIT;
        end
        ST_K1_WAIT: begin
          if (div_stat.done) begin
            k1 <= gain_of(div_quo, div_stat.ovf, p01[DATA_W-1] ^ s[OP_W-1]);
            idx <= '0;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          case (idx)
            3'd2: ang <= sat32(SUM_W'(theta) + SUM_W'(mul_res));
            3'd3: bia <= sat32(SUM_W'(bia) + SUM_W'(mul_res));
            3'd4: p01a <= sat32(SUM_W'(p01) - SUM_W'(mul_res));
            3'd5: p10 <= sat32(SUM_W'(p01) - SUM_W'(mul_res));
            3'd6: va <= sat32(SUM_W'(p00) - SUM_W'(mul_res));
            3'd7: vb <= sat32(SUM_W'(p11) - SUM_W'(mul_res));
            default: ;
          endcase
          idx <= idx + 3'd1;
          if (idx == 3'd7) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (!out_valid || out_ready) begin
            if (!bad) begin
              angle_est[ax] <= ang;
              bias_est[ax] <= bia;
              var_angle[ax] <= va;
              var_bias[ax] <= vb;
              cov_cross[ax] <= cov_new;
            end
            filtered_angle <= bad ? '0 : ang;
            bias_estimate <= bad ? '0 : bia;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `KABF_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
  `KABF_IMPL(a_out_from_wb, $rose(out_valid), $past(state) == ST_WB, "result outside write-back")
  `KABF_IMPL(a_dt_range, state == ST_MUL1, !dt[DT_W-1] || dt[DT_W-2:0] == '0, "step time above 1 s")

endmodule
